FILE: rtl/cps_pkg.sv
`default_nettype none
package cps_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [15:0] MATCH_WINDOW_RST   = 16'd1000;
  localparam logic [31:0] PRECHARGE_LIMIT_RST = 32'd5000;
  localparam logic [31:0] CLOSE_LIMIT_RST     = 32'd500;
  localparam logic [31:0] OPEN_LIMIT_RST      = 32'd500;

  typedef enum logic [1:0] {
    REG_MATCH_WINDOW    = 2'd0,
    REG_PRECHARGE_LIMIT = 2'd1,
    REG_CLOSE_LIMIT     = 2'd2,
    REG_OPEN_LIMIT      = 2'd3
  } reg_idx_t;

  localparam logic ACTION_STEP  = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    MODE_OPEN         = 3'd0,
    MODE_PRECHARGE    = 3'd1,
    MODE_MAIN_CLOSING = 3'd2,
    MODE_CLOSED       = 3'd3,
    MODE_OPENING      = 3'd4,
    MODE_WELDED       = 3'd5
  } mode_t;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic [15:0] pack_mv;
    logic [15:0] bus_mv;
    logic        main_fb_closed;
    logic        pre_fb_closed;
    logic        close_request;
    logic        close_inhibit;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode_code;
    logic       drive_pre;
    logic       drive_main;
    logic       voltages_matched;
    logic       connection_ready;
    logic       welded_flag;
    logic       feedback_flag;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/cps_if.sv
`default_nettype none
interface cps_in_if;
  import cps_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cps_out_if;
  import cps_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/contactor_precharge_sequencer.sv
`default_nettype none
// channel  | dir | handshake             | payload
// in_ch    | in  | valid/ready           | action, now_ms, pack_mv, bus_mv, feedback, request
// out_ch   | out | valid/ready           | mode_code, drives, status, fault flags
// cfg_*    | in  | apb, pready tied high | four registers at byte address 4*i
//
// an item is taken into the input register, then decided combinationally against the
// sequencer state and written to the result register; one item per cycle sustained
// when out_ch is not stalled
// a clear transaction updates state and gives no result
// rst_n is synchronous, active low; configuration returns to its defaults
// a stalled result holds the result register, which backs up into the input register
module contactor_precharge_sequencer (
  input  wire                                 clk,
  input  wire                                 rst_n,
  cps_in_if.sink                              in_ch,
  cps_out_if.source                           out_ch,
  input  wire                                 cfg_psel,
  input  wire                                 cfg_penable,
  input  wire                                 cfg_pwrite,
  input  wire  [cps_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire  [cps_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [cps_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import cps_pkg::*;

  logic [15:0] match_window_r;
  logic [31:0] precharge_limit_r;
  logic [31:0] close_limit_r;
  logic [31:0] open_limit_r;

  logic        in_valid_r;
  in_item_t    in_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  mode_t       mode_r, mode_nxt;
  logic [31:0] entered_r, entered_nxt;
  logic        welded_r, welded_nxt;
  logic        feedback_r, feedback_nxt;

  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  logic        is_clear;
  logic        out_free;
  logic        fire;
  logic [15:0] delta;
  logic        matched;
  logic        want;
  logic [31:0] elapsed;
  mode_t       mode_cur;
  out_item_t   result;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_window_r    <= MATCH_WINDOW_RST;
      precharge_limit_r <= PRECHARGE_LIMIT_RST;
      close_limit_r     <= CLOSE_LIMIT_RST;
      open_limit_r      <= OPEN_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MATCH_WINDOW:    match_window_r    <= cfg_pwdata[15:0];
        REG_PRECHARGE_LIMIT: precharge_limit_r <= cfg_pwdata;
        REG_CLOSE_LIMIT:     close_limit_r     <= cfg_pwdata;
        REG_OPEN_LIMIT:      open_limit_r      <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MATCH_WINDOW:    cfg_prdata = {16'd0, match_window_r};
      REG_PRECHARGE_LIMIT: cfg_prdata = precharge_limit_r;
      REG_CLOSE_LIMIT:     cfg_prdata = close_limit_r;
      REG_OPEN_LIMIT:      cfg_prdata = open_limit_r;
      default:             cfg_prdata = '0;
    endcase
  end

  // handshake
  assign is_clear     = (in_data_r.action == ACTION_CLEAR);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign fire         = in_valid_r && (is_clear || out_free);
  assign in_ch.ready  = !in_valid_r || fire;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_data_r <= in_ch.data;
    end
  end

  // decision inputs
  assign delta   = (in_data_r.pack_mv >= in_data_r.bus_mv) ?
                   in_data_r.pack_mv - in_data_r.bus_mv :
                   in_data_r.bus_mv - in_data_r.pack_mv;
  assign matched = (delta <= match_window_r);
  assign want    = in_data_r.close_request && !in_data_r.close_inhibit;
  assign elapsed = in_data_r.now_ms - entered_r;
  assign mode_cur = welded_r ? MODE_WELDED : mode_r;

  // next state
  always_comb begin
    mode_nxt     = mode_cur;
    entered_nxt  = entered_r;
    welded_nxt   = welded_r;
    feedback_nxt = feedback_r;
    if (is_clear) begin
      mode_nxt     = MODE_OPEN;
      entered_nxt  = in_data_r.now_ms;
      welded_nxt   = 1'b0;
      feedback_nxt = 1'b0;
    end else begin
      case (mode_cur)
        MODE_OPEN: begin
          if (in_data_r.main_fb_closed) begin
            welded_nxt  = 1'b1;
            mode_nxt    = MODE_WELDED;
            entered_nxt = in_data_r.now_ms;
          end else if (want) begin
            mode_nxt    = matched ? MODE_MAIN_CLOSING : MODE_PRECHARGE;
            entered_nxt = in_data_r.now_ms;
          end
        end
        MODE_PRECHARGE: begin
          if (!want) begin
            mode_nxt    = MODE_OPENING;
            entered_nxt = in_data_r.now_ms;
          end else if (matched) begin
            mode_nxt    = MODE_MAIN_CLOSING;
            entered_nxt = in_data_r.now_ms;
          end else if (elapsed > precharge_limit_r) begin
            feedback_nxt = 1'b1;
            mode_nxt     = MODE_OPENING;
            entered_nxt  = in_data_r.now_ms;
          end
        end
        MODE_MAIN_CLOSING: begin
          if (!want) begin
            mode_nxt    = MODE_OPENING;
            entered_nxt = in_data_r.now_ms;
          end else if (in_data_r.main_fb_closed) begin
            mode_nxt    = MODE_CLOSED;
            entered_nxt = in_data_r.now_ms;
          end else if (elapsed > close_limit_r) begin
            feedback_nxt = 1'b1;
            mode_nxt     = MODE_OPENING;
            entered_nxt  = in_data_r.now_ms;
          end
        end
        MODE_CLOSED: begin
          if (!want) begin
            mode_nxt    = MODE_OPENING;
            entered_nxt = in_data_r.now_ms;
          end else if (!in_data_r.main_fb_closed) begin
            feedback_nxt = 1'b1;
            mode_nxt     = MODE_OPENING;
            entered_nxt  = in_data_r.now_ms;
          end
        end
        MODE_OPENING: begin
          if (!in_data_r.main_fb_closed && !in_data_r.pre_fb_closed) begin
            mode_nxt    = MODE_OPEN;
            entered_nxt = in_data_r.now_ms;
          end else if (elapsed > open_limit_r) begin
            entered_nxt = in_data_r.now_ms;
            if (in_data_r.main_fb_closed) begin
              welded_nxt = 1'b1;
              mode_nxt   = MODE_WELDED;
            end else begin
              mode_nxt = MODE_OPEN;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    result.mode_code        = mode_nxt;
    result.drive_pre        = (mode_nxt == MODE_PRECHARGE) || (mode_nxt == MODE_MAIN_CLOSING);
    result.drive_main       = (mode_nxt == MODE_MAIN_CLOSING) || (mode_nxt == MODE_CLOSED);
    result.voltages_matched = matched;
    result.connection_ready = (mode_nxt == MODE_CLOSED) && in_data_r.main_fb_closed;
    result.welded_flag      = welded_nxt;
    result.feedback_flag    = feedback_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_OPEN;
      entered_r  <= '0;
      welded_r   <= 1'b0;
      feedback_r <= 1'b0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      entered_r  <= entered_nxt;
      welded_r   <= welded_nxt;
      feedback_r <= feedback_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && !is_clear) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_clear) begin
      out_data_r <= result;
    end
  end

  a_welded_mode: assert property (@(posedge clk) disable iff (!rst_n)
    welded_r |-> mode_r == MODE_WELDED)
    else $error("welded latch set outside welded mode");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_clear |=> !welded_r && !feedback_r && mode_r == MODE_OPEN)
    else $error("clear transaction did not reset the sequencer");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r && $stable(in_data_r))
    else $error("pending input item lost");

  a_ready_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.connection_ready |-> out_data_r.drive_main)
    else $error("connection ready without main drive");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result overwritten");

endmodule
`default_nettype wire

FILE: tb/contactor_precharge_sequencer_tb.sv
`timescale 1ns / 100ps

module contactor_precharge_sequencer_tb;
  import cps_pkg::*;

  // tracks the sequencer state and the status words still owed by the block
  class contactor_tracker;
    logic [15:0] window_mv;
    logic [31:0] precharge_ms;
    logic [31:0] close_ms;
    logic [31:0] open_ms;
    mode_t       mode;
    logic [31:0] entered_ms;
    bit          welded;
    bit          fb_fault;
    out_item_t   status_q[$];
    int          errors;

    function void reset();
      window_mv    = MATCH_WINDOW_RST;
      precharge_ms = PRECHARGE_LIMIT_RST;
      close_ms     = CLOSE_LIMIT_RST;
      open_ms      = OPEN_LIMIT_RST;
      mode         = MODE_OPEN;
      entered_ms   = '0;
      welded       = 1'b0;
      fb_fault     = 1'b0;
      status_q.delete();
      errors       = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_MATCH_WINDOW:    window_mv = value[15:0];
        REG_PRECHARGE_LIMIT: precharge_ms = value;
        REG_CLOSE_LIMIT:     close_ms = value;
        REG_OPEN_LIMIT:      open_ms = value;
        default: ;
      endcase
    endfunction

    function void enter(mode_t next, logic [31:0] now);
      mode       = next;
      entered_ms = now;
    endfunction

    function void sequence_step(in_item_t it);
      logic [15:0] delta;
      logic [31:0] elapsed;
      bit          matched;
      bit          want;
      out_item_t   st;
      if (it.action == ACTION_CLEAR) begin
        welded   = 1'b0;
        fb_fault = 1'b0;
        enter(MODE_OPEN, it.now_ms);
        return;
      end
      delta   = (it.pack_mv >= it.bus_mv) ? it.pack_mv - it.bus_mv : it.bus_mv - it.pack_mv;
      matched = (delta <= window_mv);
      want    = it.close_request && !it.close_inhibit;
      elapsed = it.now_ms - entered_ms;
      if (welded) mode = MODE_WELDED;
      case (mode)
        MODE_OPEN: begin
          if (it.main_fb_closed) begin
            welded = 1'b1;
            enter(MODE_WELDED, it.now_ms);
          end else if (want) begin
            enter(matched ? MODE_MAIN_CLOSING : MODE_PRECHARGE, it.now_ms);
          end
        end
        MODE_PRECHARGE: begin
          if (!want) begin
            enter(MODE_OPENING, it.now_ms);
          end else if (matched) begin
            enter(MODE_MAIN_CLOSING, it.now_ms);
          end else if (elapsed > precharge_ms) begin
            fb_fault = 1'b1;
            enter(MODE_OPENING, it.now_ms);
          end
        end
        MODE_MAIN_CLOSING: begin
          if (!want) begin
            enter(MODE_OPENING, it.now_ms);
          end else if (it.main_fb_closed) begin
            enter(MODE_CLOSED, it.now_ms);
          end else if (elapsed > close_ms) begin
            fb_fault = 1'b1;
            enter(MODE_OPENING, it.now_ms);
          end
        end
        MODE_CLOSED: begin
          if (!want) begin
            enter(MODE_OPENING, it.now_ms);
          end else if (!it.main_fb_closed) begin
            fb_fault = 1'b1;
            enter(MODE_OPENING, it.now_ms);
          end
        end
        MODE_OPENING: begin
          if (!it.main_fb_closed && !it.pre_fb_closed) begin
            enter(MODE_OPEN, it.now_ms);
          end else if (elapsed > open_ms) begin
            if (it.main_fb_closed) begin
              welded = 1'b1;
              enter(MODE_WELDED, it.now_ms);
            end else begin
              enter(MODE_OPEN, it.now_ms);
            end
          end
        end
        default: ;
      endcase
      st.mode_code        = mode;
      st.drive_pre        = (mode == MODE_PRECHARGE || mode == MODE_MAIN_CLOSING);
      st.drive_main       = (mode == MODE_MAIN_CLOSING || mode == MODE_CLOSED);
      st.voltages_matched = matched;
      st.connection_ready = (mode == MODE_CLOSED) && it.main_fb_closed;
      st.welded_flag      = welded;
      st.feedback_flag    = fb_fault;
      status_q.push_back(st);
    endfunction

    function void match_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void compare_status(out_item_t got);
      out_item_t want;
      if (status_q.size() == 0) begin
        $error("status transaction with none outstanding: %h", got);
        errors++;
        return;
      end
      want = status_q.pop_front();
      match_field("mode_code", 32'(want.mode_code), 32'(got.mode_code));
      match_field("drive_pre", 32'(want.drive_pre), 32'(got.drive_pre));
      match_field("drive_main", 32'(want.drive_main), 32'(got.drive_main));
      match_field("voltages_matched", 32'(want.voltages_matched), 32'(got.voltages_matched));
      match_field("connection_ready", 32'(want.connection_ready), 32'(got.connection_ready));
      match_field("welded_flag", 32'(want.welded_flag), 32'(got.welded_flag));
      match_field("feedback_flag", 32'(want.feedback_flag), 32'(got.feedback_flag));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    p_send = 0;
  int                    p_recv = 0;
  logic [31:0]           t_now;

  contactor_tracker tracker = new();

  cps_in_if  in_ch ();
  cps_out_if out_ch ();

  contactor_precharge_sequencer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result first: a transaction accepted at this edge cannot have its result out yet
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) tracker.compare_status(out_ch.data);
      if (in_ch.valid && in_ch.ready) tracker.sequence_step(in_ch.data);
    end
  end

  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= p_recv);
    end
  end

  function automatic in_item_t mk(logic act, logic [31:0] now, logic [15:0] pack,
                                  logic [15:0] bus, logic mfb, logic pfb, logic req,
                                  logic inh);
    in_item_t it;
    it.action         = act;
    it.now_ms         = now;
    it.pack_mv        = pack;
    it.bus_mv         = bus;
    it.main_fb_closed = mfb;
    it.pre_fb_closed  = pfb;
    it.close_request  = req;
    it.close_inhibit  = inh;
    return it;
  endfunction

  // mostly plausible contactor behavior for the predicted mode, some pure noise
  function automatic in_item_t next_step();
    in_item_t    it;
    logic [31:0] lim;
    int          r;
    int          pk;
    int          bs;
    int          d;
    int          w;
    if ($urandom_range(99) < 12) begin
      it.action         = ($urandom_range(9) == 0);
      it.now_ms         = $urandom;
      it.pack_mv        = 16'($urandom);
      it.bus_mv         = 16'($urandom);
      it.main_fb_closed = 1'($urandom);
      it.pre_fb_closed  = 1'($urandom);
      it.close_request  = 1'($urandom);
      it.close_inhibit  = 1'($urandom);
      t_now = it.now_ms;
      return it;
    end
    case (tracker.mode)
      MODE_PRECHARGE:    lim = tracker.precharge_ms;
      MODE_MAIN_CLOSING: lim = tracker.close_ms;
      MODE_OPENING:      lim = tracker.open_ms;
      default:           lim = 32'd20;
    endcase
    r = int'($urandom_range(99));
    if (r < 65) t_now = t_now + 32'($urandom_range(20));
    // land on either side of the strict timeout boundary
    else if (r < 90) t_now = tracker.entered_ms + lim + 32'($urandom_range(2)) - 32'd1;
    else t_now = t_now + $urandom;
    it.now_ms = t_now;

    pk = int'($urandom_range(65535));
    w  = int'(tracker.window_mv);
    r  = int'($urandom_range(99));
    if (r < 45) d = int'($urandom_range(w));
    else if (r < 60) d = w;
    else if (r < 75) d = w + 1;
    else d = w + 1 + int'($urandom_range(20000));
    if (d > 65535) bs = int'($urandom_range(65535));
    else if (pk >= d && ($urandom_range(1) == 1 || pk + d > 65535)) bs = pk - d;
    else if (pk + d <= 65535) bs = pk + d;
    else bs = int'($urandom_range(65535));
    it.pack_mv = 16'(pk);
    it.bus_mv  = 16'(bs);

    case (tracker.mode)
      MODE_OPEN: begin
        it.main_fb_closed = ($urandom_range(99) < 4);
        it.pre_fb_closed  = ($urandom_range(99) < 10);
      end
      MODE_PRECHARGE: begin
        it.main_fb_closed = ($urandom_range(99) < 5);
        it.pre_fb_closed  = ($urandom_range(99) < 90);
      end
      MODE_MAIN_CLOSING: begin
        it.main_fb_closed = ($urandom_range(99) < 40);
        it.pre_fb_closed  = ($urandom_range(99) < 90);
      end
      MODE_CLOSED: begin
        it.main_fb_closed = ($urandom_range(99) < 92);
        it.pre_fb_closed  = 1'($urandom);
      end
      MODE_OPENING: begin
        if ($urandom_range(99) < 50) begin
          it.main_fb_closed = 1'b0;
          it.pre_fb_closed  = 1'b0;
        end else begin
          it.main_fb_closed = ($urandom_range(99) < 40);
          it.pre_fb_closed  = ($urandom_range(99) < 60);
        end
      end
      default: begin
        it.main_fb_closed = 1'($urandom);
        it.pre_fb_closed  = 1'($urandom);
      end
    endcase
    it.close_request = (tracker.mode == MODE_OPEN) ? ($urandom_range(99) < 70)
                                                   : ($urandom_range(99) < 93);
    it.close_inhibit = ($urandom_range(99) < 6);
    if (tracker.mode == MODE_WELDED) it.action = ($urandom_range(99) < 25);
    else it.action = ($urandom_range(99) < 2);
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < p_send) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.data  = it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.set_reg(idx, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic program_limits(input logic [15:0] w, input logic [31:0] pre,
                                input logic [31:0] cls, input logic [31:0] opn);
    // junk in the unused upper half of the window register
    apb_write(REG_MATCH_WINDOW, {16'($urandom), w});
    apb_write(REG_PRECHARGE_LIMIT, pre);
    apb_write(REG_CLOSE_LIMIT, cls);
    apb_write(REG_OPEN_LIMIT, opn);
  endtask

  // clear transactions give no status, so allow the pipeline to empty as well
  task automatic drain();
    in_ch.valid = 1'b0;
    while (tracker.status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("[contactor_precharge_sequencer] ERROR");
    $finish;
  end

  initial begin
    int n;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    tracker.reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed walk through every mode at the reset limits
    send_item(mk(ACTION_STEP, 32'd10, 16'd40000, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(mk(ACTION_STEP, 32'd20, 16'd40000, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd100, 16'd40000, 16'd38999, 1'b0, 1'b1, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd120, 16'd40000, 16'd39000, 1'b0, 1'b1, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd620, 16'd40000, 16'd40000, 1'b0, 1'b1, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd630, 16'd40000, 16'd40000, 1'b1, 1'b1, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd640, 16'd40000, 16'd40000, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd650, 16'd40000, 16'd40000, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd1151, 16'd40000, 16'd40000, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk(ACTION_STEP, 32'd1200, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_CLEAR, 32'd1300, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk(ACTION_STEP, 32'd1310, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk(ACTION_CLEAR, 32'hFFFF_FFF0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    // close timeout measured across the timestamp wrap
    send_item(mk(ACTION_STEP, 32'hFFFF_FFF8, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'h0000_01EC, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'h0000_01ED, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'h0000_0200, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(mk(ACTION_STEP, 32'h0000_03E2, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(mk(ACTION_STEP, 32'd1000, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd6000, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd6001, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd6010, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk(ACTION_STEP, 32'd6020, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk(ACTION_STEP, 32'd6030, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(ACTION_STEP, 32'd6040, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0));
    send_item(mk(ACTION_CLEAR, 32'd6050, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    t_now = 32'd6050;

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: program_limits(16'd0, 32'd0, 32'd0, 32'd0);
          2: program_limits(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          5: program_limits(16'($urandom), $urandom, $urandom, $urandom);
          default: program_limits(16'($urandom_range(3000)), 32'($urandom_range(400)),
                                  32'($urandom_range(400)), 32'($urandom_range(400)));
        endcase
      end
      case (ph % 4)
        0: begin p_send = 0;  p_recv = 0;  end
        1: begin p_send = 52; p_recv = 0;  end
        2: begin p_send = 0;  p_recv = 52; end
        default: begin p_send = 26; p_recv = 26; end
      endcase
      for (n = 0; n < 238; n++) send_item(next_step());
      in_ch.valid = 1'b0;
    end

    drain();
    repeat (8) @(negedge clk);
    if (tracker.status_q.size() != 0) begin
      $error("%0d status transactions never arrived", tracker.status_q.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("[contactor_precharge_sequencer] OK");
    end else begin
      $display("[contactor_precharge_sequencer] ERROR");
    end
    $finish;
  end

endmodule
